FILE: src/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int CELL_COUNT     = COLUMNS * ROWS;
  localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W         = $clog2(CELL_COUNT);
  localparam int CURSOR_W       = 11;
  localparam int COL_W          = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Character and attribute constants
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] RESET_ATTR   = 8'd15;
  localparam logic [7:0] BLANK_CHAR   = 8'd0;

  // Input operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Command queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [7:0]  attr;
    logic [10:0] cell_index;
  } tcw_item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_cell;
    logic [7:0]          read_char;
    logic [7:0]          read_attr;
    logic                scrolled;
  } tcw_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] at;
  } tcw_cell_t;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } tcw_kind_t;

  typedef struct packed {
    tcw_kind_t   kind;
    logic [7:0]  char_code;
    logic [7:0]  attr;
    logic [10:0] cell_index;
    logic        in_range;
  } tcw_cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCROLL_COPY,
    ST_SCROLL_BLANK,
    ST_SCROLL_PUT,
    ST_CLEAR
  } tcw_state_t;

endpackage

FILE: src/tcw_front.sv
// Front end: accepts input transactions and classifies them into commands.
module tcw_front import tcw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  tcw_item_t item,
  input  logic      init_busy,
  output logic      push,
  output tcw_cmd_t  push_cmd,
  input  logic      queue_full
);

  logic      front_valid;
  logic      front_valid_next;
  tcw_cmd_t  front_cmd;
  tcw_cmd_t  cmd_next;
  logic      accept;

  // Hold off while the screen is still being cleared after reset, or while a command is held and the queue is full
  assign item_stall = init_busy || (front_valid && queue_full);
  assign accept     = item_valid && !item_stall;
  assign push       = front_valid && !queue_full;
  assign push_cmd   = front_cmd;

  // Classify the operation
  always_comb begin
    cmd_next.char_code  = item.char_code;
    cmd_next.attr       = item.attr;
    cmd_next.cell_index = item.cell_index;
    cmd_next.in_range   = ({1'b0, item.cell_index} < 12'(CELL_COUNT));
    case (item.op)
      OP_PUT: begin
        cmd_next.kind = (item.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
      end
      OP_CLEAR: cmd_next.kind = CMD_CLEAR;
      OP_READ:  cmd_next.kind = CMD_READ;
      default:  cmd_next.kind = CMD_NOP;
    endcase
  end

  always_comb begin
    front_valid_next = front_valid;
    if (accept) begin
      front_valid_next = 1'b1;
    end else if (push) begin
      front_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_cmd <= cmd_next;
    end
  end

endmodule

FILE: src/tcw_queue.sv
// Short command queue between the front and back ends.
module tcw_queue import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tcw_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output tcw_cmd_t head_cmd
);

  tcw_cmd_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic [QPTR_W:0]     count_next;

  assign full       = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: src/tcw_back.sv
// Back end: screen memory, cursor and the sequencer for put, scroll, clear and read.
module tcw_back import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        head_valid,
  input  tcw_cmd_t    head_cmd,
  output logic        pop,
  output logic        init_busy,
  output logic        result_valid,
  input  logic        result_stall,
  output tcw_result_t result
);

  tcw_cell_t           mem [CELL_COUNT];
  tcw_cell_t           rdata;

  tcw_state_t          state;
  tcw_state_t          state_next;
  logic [ADDR_W-1:0]   cnt;
  logic [ADDR_W-1:0]   cnt_next;
  logic [CURSOR_W-1:0] cursor;
  logic [CURSOR_W-1:0] cursor_next;
  logic [COL_W-1:0]    col;
  logic [COL_W-1:0]    col_next;
  logic [7:0]          blank_attr;
  tcw_cmd_t            cmd;

  logic                mem_we;
  logic [ADDR_W-1:0]   wr_addr;
  tcw_cell_t           wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                res_load;
  tcw_result_t         res_data;
  logic                at_end;
  logic                on_last_row;
  logic                cnt_last;
  logic                cnt_last_row;
  logic [COL_W-1:0]    col_inc;

  assign init_busy    = (state == ST_INIT);
  assign pop          = (state == ST_IDLE) && head_valid && (!result_valid || !result_stall);
  assign at_end       = (cursor == CURSOR_W'(CELL_COUNT));
  assign on_last_row  = (cursor >= CURSOR_W'(LAST_ROW_START));
  assign cnt_last     = (cnt == ADDR_W'(CELL_COUNT - 1));
  assign cnt_last_row = (cnt == ADDR_W'(LAST_ROW_START));
  assign col_inc      = (col == COL_W'(COLUMNS - 1)) ? '0 : col + 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop) begin
          case (head_cmd.kind)
            CMD_PUT:     if (at_end) state_next = ST_SCROLL_COPY;
            CMD_NEWLINE: if (on_last_row) state_next = ST_SCROLL_COPY;
            CMD_CLEAR:   state_next = ST_CLEAR;
            CMD_READ:    if (head_cmd.in_range) state_next = ST_READ_WAIT;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ_WAIT:   state_next = ST_IDLE;
      ST_SCROLL_COPY: begin
        if (cnt_last_row) state_next = ST_SCROLL_BLANK;
      end
      ST_SCROLL_BLANK: begin
        if (cnt_last) state_next = (cmd.kind == CMD_PUT) ? ST_SCROLL_PUT : ST_IDLE;
      end
      ST_SCROLL_PUT:  state_next = ST_IDLE;
      ST_CLEAR: begin
        if (cnt_last) state_next = ST_IDLE;
      end
      default:        state_next = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    mem_we      = 1'b0;
    wr_addr     = cnt;
    wr_data     = '{ch: BLANK_CHAR, at: blank_attr};
    rd_en       = 1'b0;
    rd_addr     = head_cmd.cell_index[ADDR_W-1:0];
    res_load    = 1'b0;
    res_data    = '0;
    cnt_next    = cnt;
    cursor_next = cursor;
    col_next    = col;
    case (state)
      ST_INIT: begin
        mem_we   = 1'b1;
        wr_data  = '{ch: BLANK_CHAR, at: RESET_ATTR};
        cnt_next = ADDR_W'(cnt + 1'b1);
      end
      ST_IDLE: begin
        if (pop) begin
          cnt_next = '0;
          case (head_cmd.kind)
            CMD_PUT: begin
              if (!at_end) begin
                mem_we      = 1'b1;
                wr_addr     = cursor[ADDR_W-1:0];
                wr_data     = '{ch: head_cmd.char_code, at: head_cmd.attr};
                cursor_next = cursor + 1'b1;
                col_next    = col_inc;
                res_load    = 1'b1;
                res_data.cursor_cell = cursor_next;
              end
            end
            CMD_NEWLINE: begin
              if (!on_last_row) begin
                cursor_next = CURSOR_W'(cursor - CURSOR_W'(col) + CURSOR_W'(COLUMNS));
                col_next    = '0;
                res_load    = 1'b1;
                res_data.cursor_cell = cursor_next;
              end
            end
            CMD_CLEAR: begin
              res_load = 1'b0;
            end
            CMD_READ: begin
              if (head_cmd.in_range) begin
                rd_en = 1'b1;
              end else begin
                res_load = 1'b1;
                res_data.cursor_cell = cursor;
              end
            end
            default: begin
              res_load = 1'b1;
              res_data.cursor_cell = cursor;
            end
          endcase
        end
      end
      ST_READ_WAIT: begin
        res_load             = 1'b1;
        res_data.cursor_cell = cursor;
        res_data.read_char   = rdata.ch;
        res_data.read_attr   = rdata.at;
      end
      ST_SCROLL_COPY: begin
        // Read one row ahead, write back the cell read in the previous cycle
        if (!cnt_last_row) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(cnt + ADDR_W'(COLUMNS));
        end
        if (cnt != '0) begin
          mem_we  = 1'b1;
          wr_addr = ADDR_W'(cnt - 1'b1);
          wr_data = rdata;
        end
        if (!cnt_last_row) cnt_next = ADDR_W'(cnt + 1'b1);
      end
      ST_SCROLL_BLANK: begin
        mem_we   = 1'b1;
        cnt_next = ADDR_W'(cnt + 1'b1);
        if (cnt_last) begin
          cursor_next = CURSOR_W'(LAST_ROW_START);
          col_next    = '0;
          if (cmd.kind != CMD_PUT) begin
            res_load             = 1'b1;
            res_data.cursor_cell = CURSOR_W'(LAST_ROW_START);
            res_data.scrolled    = 1'b1;
          end
        end
      end
      ST_SCROLL_PUT: begin
        // Deferred character lands at the start of the fresh last row
        mem_we               = 1'b1;
        wr_addr              = cursor[ADDR_W-1:0];
        wr_data              = '{ch: cmd.char_code, at: cmd.attr};
        cursor_next          = cursor + 1'b1;
        col_next             = col_inc;
        res_load             = 1'b1;
        res_data.cursor_cell = cursor_next;
        res_data.scrolled    = 1'b1;
      end
      ST_CLEAR: begin
        mem_we   = 1'b1;
        cnt_next = ADDR_W'(cnt + 1'b1);
        if (cnt_last) begin
          cursor_next          = '0;
          col_next             = '0;
          res_load             = 1'b1;
          res_data.cursor_cell = '0;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      cnt          <= '0;
      cursor       <= '0;
      col          <= '0;
      blank_attr   <= RESET_ATTR;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      cursor <= cursor_next;
      col    <= col_next;
      if (cfg_wr_en) begin
        blank_attr <= cfg_wr_data;
      end
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head_cmd;
    end
    if (res_load) begin
      result <= res_data;
    end
  end

  // Screen memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

FILE: src/text_console_writer.sv
// Top level of the text console writer: front end, command queue, back end.
// Commands pass the front register and a queue entry; the back end registers results.
// Scroll: row copy, then last-row blank, through the screen memory's single write port;
// a deferred character then lands on the last row; reads add the memory read register.
// Throughput: one put per cycle via the single memory write port, unless stalled.
// Reset: synchronous; a clearing pass over all ROWS*COLUMNS (2000) cells stalls input.
module text_console_writer import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  tcw_item_t   item,
  output logic        result_valid,
  input  logic        result_stall,
  output tcw_result_t result,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic     init_busy;
  logic     push;
  tcw_cmd_t push_cmd;
  logic     queue_full;
  logic     pop;
  logic     head_valid;
  tcw_cmd_t head_cmd;

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .init_busy  (init_busy),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .init_busy    (init_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
